/* rtl/medical_pixel_window_level_defines.svh */
// Assertion macros shared by the top and divider RTL files. Expect clk and rst_n in scope.
`ifndef MEDICAL_PIXEL_WINDOW_LEVEL_DEFINES_SVH
`define MEDICAL_PIXEL_WINDOW_LEVEL_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define MPWL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define MPWL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/mpwl_pkg.sv */
package mpwl_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned PixW    = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NumW    = 24;
  localparam int unsigned QuotW   = 8;
  localparam int unsigned StepW   = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_FORMAT   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CENTER   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WIDTH    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_FB_LOW   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FB_HIGH  = 3'd4;

  // pixel format codes; both remaining codes select RGB
  localparam logic [1:0] FMT_MONO16 = 2'd0;
  localparam logic [1:0] FMT_MONO8  = 2'd1;
  localparam logic [1:0] FMT_RGB    = 2'd2;

  localparam logic signed [PixW-1:0] PIX_OFFSET  = 16'sd2000;
  localparam logic signed [PixW-1:0] BYTE_MAX    = 16'sd2255;
  localparam logic signed [PixW-1:0] MIN_RESET   = 16'sh7fff;
  localparam logic signed [PixW-1:0] MAX_RESET   = 16'sh8000;

  // Q16 luma weights
  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  localparam logic [StepW-1:0] LAST_STEP = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUMA,
    ST_PREP,
    ST_SCALE,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_stat_t;

  typedef struct packed {
    logic              start_of_image;
    logic [PixW-1:0]   sample_a;
    logic [ByteW-1:0]  sample_b;
    logic [ByteW-1:0]  sample_c;
  } in_t;

  typedef struct packed {
    logic signed [PixW-1:0] offset_pixel;
    logic [ByteW-1:0]       display_value;
    logic signed [PixW-1:0] image_min;
    logic signed [PixW-1:0] image_max;
  } out_t;

endpackage

/* rtl/medical_pixel_window_level.sv */
// Window/level of one pixel to an 8-bit display value. A pixel is taken as a
// signed 16-bit word, a gray byte or an RGB triple (reduced to 8-bit luma
// by Q16 weights), offset by 2000 with 16-bit wrap, clamped to center -/+
// width/2 (or to the fallback bounds when width is zero) and scaled by
// (v-lower)*255/span. Running min/max of the offset values are kept for
// 16-bit images. One pixel is in flight at a time. A bit-serial luma unit
// reduces an RGB pixel first, and a serial divider then scales it unless
// the window is empty, in which case no division runs and the display
// value is zero. A finished result sits in the output register, so the
// next pixel is taken while it waits.
// Configuration writes are always ready; write them only with no pixel
// in flight.
`include "medical_pixel_window_level_defines.svh"

module medical_pixel_window_level (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mpwl_pkg::in_t                      in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mpwl_pkg::out_t                     out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mpwl_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [mpwl_pkg::PixW-1:0]          cfg_data
);

  mpwl_pkg::state_t                     state_r;
  mpwl_pkg::state_t                     state_nxt;

  logic [1:0]                           fmt_r;
  logic signed [mpwl_pkg::PixW-1:0]     center_r;
  logic [mpwl_pkg::PixW-1:0]            width_r;
  logic signed [mpwl_pkg::PixW-1:0]     fb_low_r;
  logic signed [mpwl_pkg::PixW-1:0]     fb_high_r;

  logic signed [mpwl_pkg::PixW-1:0]     running_min_r;
  logic signed [mpwl_pkg::PixW-1:0]     running_max_r;

  logic                                 sof_r;
  logic [mpwl_pkg::PixW-1:0]            sa_r;
  logic signed [mpwl_pkg::PixW-1:0]     offv_r;
  logic signed [mpwl_pkg::PixW-1:0]     lower_r;
  logic signed [mpwl_pkg::PixW-1:0]     upper_r;
  logic signed [mpwl_pkg::PixW-1:0]     omin_r;
  logic signed [mpwl_pkg::PixW-1:0]     omax_r;
  logic                                 zero_r;

  logic                                 out_valid_r;
  mpwl_pkg::out_t                       out_data_r;

  logic                                 is_rgb;
  logic                                 in_xfer;
  logic                                 luma_start;
  logic                                 div_start;
  logic                                 out_load;

  mpwl_pkg::ser_stat_t                  luma_st;
  mpwl_pkg::ser_stat_t                  div_st;
  logic [mpwl_pkg::ByteW-1:0]           luma;
  logic [mpwl_pkg::QuotW-1:0]           quot;

  logic [mpwl_pkg::PixW-1:0]            pix;
  logic signed [mpwl_pkg::PixW-1:0]     offv;
  logic signed [mpwl_pkg::PixW-1:0]     base_min;
  logic signed [mpwl_pkg::PixW-1:0]     base_max;
  logic signed [mpwl_pkg::PixW-1:0]     min_nxt;
  logic signed [mpwl_pkg::PixW-1:0]     max_nxt;
  logic signed [mpwl_pkg::PixW-1:0]     half;
  logic signed [mpwl_pkg::PixW-1:0]     lower;
  logic signed [mpwl_pkg::PixW-1:0]     upper;

  logic signed [mpwl_pkg::PixW-1:0]     vclip;
  logic signed [mpwl_pkg::PixW-1:0]     vclamp;
  logic [mpwl_pkg::PixW-1:0]            delta;
  logic [mpwl_pkg::PixW-1:0]            span;
  logic [mpwl_pkg::NumW-1:0]            numer;
  logic                                 open_win;

  assign is_rgb    = fmt_r[1];
  assign cfg_ready = 1'b1;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= mpwl_pkg::FMT_MONO16;
      center_r  <= '0;
      width_r   <= '0;
      fb_low_r  <= mpwl_pkg::PIX_OFFSET;
      fb_high_r <= mpwl_pkg::BYTE_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mpwl_pkg::CFG_FORMAT:  fmt_r     <= cfg_data[1:0];
        mpwl_pkg::CFG_CENTER:  center_r  <= cfg_data;
        mpwl_pkg::CFG_WIDTH:   width_r   <= cfg_data;
        mpwl_pkg::CFG_FB_LOW:  fb_low_r  <= cfg_data;
        mpwl_pkg::CFG_FB_HIGH: fb_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mpwl_luma u_luma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (luma_start),
    .red   (in_data.sample_a[mpwl_pkg::ByteW-1:0]),
    .green (in_data.sample_b),
    .blue  (in_data.sample_c),
    .stat  (luma_st),
    .luma  (luma)
  );

  // offset, running min/max and window bounds
  always_comb begin
    case (fmt_r)
      mpwl_pkg::FMT_MONO16: pix = sa_r;
      mpwl_pkg::FMT_MONO8:  pix = {8'd0, sa_r[mpwl_pkg::ByteW-1:0]};
      default:              pix = {8'd0, luma};
    endcase
    offv     = pix + mpwl_pkg::PIX_OFFSET;
    base_min = sof_r ? mpwl_pkg::MIN_RESET : running_min_r;
    base_max = sof_r ? mpwl_pkg::MAX_RESET : running_max_r;
    min_nxt  = base_min;
    max_nxt  = base_max;
    if (fmt_r == mpwl_pkg::FMT_MONO16) begin
      if (offv < base_min) begin
        min_nxt = offv;
      end
      if (offv > base_max) begin
        max_nxt = offv;
      end
    end
    half = {1'b0, width_r[mpwl_pkg::PixW-1:1]};
    if (width_r == '0) begin
      lower = fb_low_r;
      upper = fb_high_r;
    end else begin
      lower = center_r - half;
      upper = center_r + half;
    end
  end

  // clamp (upper first, then lower) and numerator
  always_comb begin
    vclip    = (offv_r > upper_r) ? upper_r : offv_r;
    vclamp   = (vclip < lower_r) ? lower_r : vclip;
    delta    = vclamp - lower_r;
    span     = upper_r - lower_r;
    numer    = {delta, 8'd0} - {8'd0, delta};
    open_win = upper_r > lower_r;
  end

  mpwl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (span),
    .stat  (div_st),
    .quot  (quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mpwl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    in_stall   = 1'b1;
    in_xfer    = 1'b0;
    luma_start = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      mpwl_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          in_xfer    = 1'b1;
          luma_start = is_rgb;
          state_nxt  = is_rgb ? mpwl_pkg::ST_LUMA : mpwl_pkg::ST_PREP;
        end
      end
      mpwl_pkg::ST_LUMA: begin
        if (luma_st.done) begin
          state_nxt = mpwl_pkg::ST_PREP;
        end
      end
      mpwl_pkg::ST_PREP: begin
        state_nxt = mpwl_pkg::ST_SCALE;
      end
      mpwl_pkg::ST_SCALE: begin
        if (open_win) begin
          div_start = 1'b1;
          state_nxt = mpwl_pkg::ST_DIV;
        end else begin
          state_nxt = mpwl_pkg::ST_FIN;
        end
      end
      mpwl_pkg::ST_DIV: begin
        if (div_st.done) begin
          state_nxt = mpwl_pkg::ST_FIN;
        end
      end
      mpwl_pkg::ST_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = mpwl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mpwl_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_min_r <= mpwl_pkg::MIN_RESET;
      running_max_r <= mpwl_pkg::MAX_RESET;
    end else if (state_r == mpwl_pkg::ST_PREP) begin
      running_min_r <= min_nxt;
      running_max_r <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      sof_r <= in_data.start_of_image;
      sa_r  <= in_data.sample_a;
    end
    if (state_r == mpwl_pkg::ST_PREP) begin
      offv_r  <= offv;
      lower_r <= lower;
      upper_r <= upper;
      omin_r  <= (fmt_r == mpwl_pkg::FMT_MONO16) ? min_nxt : mpwl_pkg::PIX_OFFSET;
      omax_r  <= (fmt_r == mpwl_pkg::FMT_MONO16) ? max_nxt : mpwl_pkg::BYTE_MAX;
    end
    if (state_r == mpwl_pkg::ST_SCALE) begin
      zero_r <= !open_win;
    end
    if (out_load) begin
      out_data_r.offset_pixel  <= offv_r;
      out_data_r.display_value <= zero_r ? '0 : quot;
      out_data_r.image_min     <= omin_r;
      out_data_r.image_max     <= omax_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MPWL_ASSERT_IMP(a_minmax_order, (state_r == mpwl_pkg::ST_SCALE) && (fmt_r == mpwl_pkg::FMT_MONO16), omin_r <= omax_r, "top: running min above running max")
  `MPWL_ASSERT_IMP(a_units_idle, state_r == mpwl_pkg::ST_IDLE, !luma_st.busy && !div_st.busy, "top: serial unit busy while idle")
  `MPWL_ASSERT_NXT(a_fin_holds, (state_r == mpwl_pkg::ST_FIN) && out_valid_r && out_stall, state_r == mpwl_pkg::ST_FIN, "top: result left while output full")

endmodule

/* rtl/mpwl_luma.sv */
module mpwl_luma (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mpwl_pkg::ByteW-1:0]      red,
  input  logic [mpwl_pkg::ByteW-1:0]      green,
  input  logic [mpwl_pkg::ByteW-1:0]      blue,
  output mpwl_pkg::ser_stat_t             stat,
  output logic [mpwl_pkg::ByteW-1:0]      luma
);

  logic                             busy_r;
  logic [mpwl_pkg::StepW-1:0]       cnt_r;
  logic [mpwl_pkg::ByteW-1:0]       red_r;
  logic [mpwl_pkg::ByteW-1:0]       green_r;
  logic [mpwl_pkg::ByteW-1:0]       blue_r;
  logic [mpwl_pkg::NumW-1:0]        acc_r;
  logic [mpwl_pkg::NumW-1:0]        term;
  logic [mpwl_pkg::NumW-1:0]        acc_nxt;

  // one bit of each byte per cycle, most significant first
  always_comb begin
    term = '0;
    if (red_r[mpwl_pkg::ByteW-1]) begin
      term = term + {8'd0, mpwl_pkg::LUMA_WR};
    end
    if (green_r[mpwl_pkg::ByteW-1]) begin
      term = term + {8'd0, mpwl_pkg::LUMA_WG};
    end
    if (blue_r[mpwl_pkg::ByteW-1]) begin
      term = term + {8'd0, mpwl_pkg::LUMA_WB};
    end
    acc_nxt = {acc_r[mpwl_pkg::NumW-2:0], 1'b0} + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == mpwl_pkg::LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      red_r   <= red;
      green_r <= green;
      blue_r  <= blue;
      acc_r   <= '0;
    end else if (busy_r) begin
      red_r   <= {red_r[mpwl_pkg::ByteW-2:0], 1'b0};
      green_r <= {green_r[mpwl_pkg::ByteW-2:0], 1'b0};
      blue_r  <= {blue_r[mpwl_pkg::ByteW-2:0], 1'b0};
      acc_r   <= acc_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == mpwl_pkg::LAST_STEP);
  assign luma      = acc_r[mpwl_pkg::NumW-1:16];

endmodule

/* rtl/mpwl_div.sv */
`include "medical_pixel_window_level_defines.svh"

module mpwl_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [mpwl_pkg::NumW-1:0]       numer,
  input  logic [mpwl_pkg::PixW-1:0]       denom,
  output mpwl_pkg::ser_stat_t             stat,
  output logic [mpwl_pkg::QuotW-1:0]      quot
);

  logic                             busy_r;
  logic [mpwl_pkg::StepW-1:0]       cnt_r;
  logic [mpwl_pkg::NumW-1:0]        rem_r;
  logic [mpwl_pkg::NumW-2:0]        dsh_r;
  logic [mpwl_pkg::PixW-1:0]        den_r;
  logic [mpwl_pkg::QuotW-1:0]       q_r;
  logic                             fits;
  logic [mpwl_pkg::NumW-1:0]        rem_nxt;

  // restoring division, one quotient bit per cycle; numer < 256 * denom
  always_comb begin
    fits    = rem_r >= {1'b0, dsh_r};
    rem_nxt = fits ? (rem_r - {1'b0, dsh_r}) : rem_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 3'd1;
      if (cnt_r == mpwl_pkg::LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= numer;
      dsh_r <= {denom, 7'd0};
      den_r <= denom;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dsh_r <= {1'b0, dsh_r[mpwl_pkg::NumW-2:1]};
      q_r   <= {q_r[mpwl_pkg::QuotW-2:0], fits};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == mpwl_pkg::LAST_STEP);
  assign quot      = q_r;

  `MPWL_ASSERT_NXT(a_rem_below_divisor, stat.done, (rem_r[mpwl_pkg::NumW-1:mpwl_pkg::PixW] == '0) && (rem_r[mpwl_pkg::PixW-1:0] < den_r), "div: remainder not below divisor")
  `MPWL_ASSERT_IMP(a_start_idle, start, !busy_r, "div: start while busy")
  `MPWL_ASSERT_IMP(a_cnt_rest, !busy_r, cnt_r == '0, "div: step count not at rest")

endmodule
